// ===== rtl/crad_pkg.sv =====
// Package with shared types and constants of the CRC aided repetition decoder.
package crad_pkg;

  localparam int BeaconRxBytes  = 24;
  localparam int BeaconOutBytes = 6;
  localparam int DataBytes      = 24;
  localparam int AckBytes       = 2;
  localparam int MaxTies        = 4;

  localparam logic [8:0]  Crc8PolyReset  = 9'h19A;
  localparam logic [16:0] Crc16PolyReset = 17'h11021;
  localparam logic [4:0]  AckThreshReset = 5'd10;
  localparam logic [7:0]  AckSetByte     = 8'h80;

  typedef enum logic [1:0] {
    FT_BEACON = 2'd0,
    FT_DATA   = 2'd1,
    FT_ACK    = 2'd2,
    FT_NONE   = 2'd3
  } ftype_t;

  typedef enum logic [1:0] {
    REG_CRC8  = 2'd0,
    REG_CRC16 = 2'd1,
    REG_ACK   = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_RECV,
    ST_VOTE,
    ST_CAND,
    ST_CRC,
    ST_CHECK,
    ST_ACK,
    ST_EMIT
  } state_t;

  // One step of the shared serial CRC unit.
  typedef struct packed {
    logic clear;
    logic step;
    logic wide;
    logic in_bit;
  } crc_ctl_t;

endpackage

// ===== rtl/crad_crc_unit.sv =====
// Bit-serial CRC register shared by the beacon and data checks.
module crad_crc_unit
  import crad_pkg::*;
(
  input  logic        clk,
  input  crc_ctl_t    ctl,
  input  logic [8:0]  poly8,
  input  logic [16:0] poly16,
  output logic [15:0] crc
);

  logic [15:0] crc_r, crc_nxt;
  logic        fb;

  always_comb begin
    fb      = (ctl.wide ? crc_r[15] : crc_r[7]) ^ ctl.in_bit;
    crc_nxt = crc_r;
    if (ctl.clear) begin
      crc_nxt = '0;
    end else if (ctl.step) begin
      if (ctl.wide) begin
        crc_nxt = {crc_r[14:0], 1'b0} ^ (fb ? poly16[15:0] : 16'h0);
      end else begin
        crc_nxt = {8'h00, crc_r[6:0], 1'b0} ^ (fb ? {8'h00, poly8[7:0]} : 16'h0);
      end
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  assign crc = crc_r;

endmodule

// ===== rtl/crc_aided_repetition_decoder_top.sv =====
// Top level of the CRC aided repetition decoder: control, store and interfaces.
//
// Usage: frame bytes enter one item at a time on the in_ channel (valid and
// ready). The frame type is sampled on the first byte of each frame; a first
// byte marked type 3 is dropped. After the last byte the block stops
// accepting and decodes:
//   beacon: a majority vote over the four copies for each output bit, then
//     per candidate a build step, a CRC pass and a check step, up to 2^K
//     candidates (K tied bits, K <= MAX_TIES); with more ties the majority
//     bytes leave unsearched and flagged as failed.
//   data: a CRC pass and a check step; acknowledge: a count of one bits.
// The decoded bytes then leave on the out_ channel, one per cycle while
// out_ready is high; a stalled receiver simply holds the current byte and
// the block waits. The CRC checks are done by one serial CRC unit under a
// small sequencer, and the store is read one byte per cycle.
// Reset (rst_n low, synchronous) restores the register defaults and starts
// a fresh frame; stored bytes are undefined until written.
// Configuration is to be written through the cfg_ APB port only while idle;
// the block itself does not enforce this.
module crc_aided_repetition_decoder_top
  import crad_pkg::*;
#(
  parameter int BEACON_RX_BYTES  = BeaconRxBytes,
  parameter int BEACON_OUT_BYTES = BeaconOutBytes,
  parameter int DATA_BYTES       = DataBytes,
  parameter int ACK_BYTES        = AckBytes,
  parameter int MAX_TIES         = MaxTies
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_frame_type,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_out_byte,
  output logic        out_check_failed,
  output logic        out_last_of_run,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int MaxLen  = (BEACON_RX_BYTES > DATA_BYTES) ? BEACON_RX_BYTES : DATA_BYTES;
  localparam int AW      = $clog2(MaxLen + 1);
  localparam int OutBits = 8 * BEACON_OUT_BYTES;
  localparam int PW      = $clog2(OutBits);
  localparam int BW      = $clog2(BEACON_OUT_BYTES);
  localparam int CW      = MAX_TIES + 1;
  localparam int TCW     = $clog2(OutBits + 1);
  localparam int BCW     = $clog2(8 * MaxLen + 1);

  // Configuration registers.
  logic [8:0]  crc8_poly_r;
  logic [16:0] crc16_poly_r;
  logic [4:0]  ack_thr_r;
  reg_idx_t    cfg_idx;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc8_poly_r  <= Crc8PolyReset;
      crc16_poly_r <= Crc16PolyReset;
      ack_thr_r    <= AckThreshReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CRC8:  crc8_poly_r  <= cfg_pwdata[8:0];
        REG_CRC16: crc16_poly_r <= cfg_pwdata[16:0];
        REG_ACK:   ack_thr_r    <= cfg_pwdata[4:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CRC8:  cfg_prdata = {23'h0, crc8_poly_r};
      REG_CRC16: cfg_prdata = {15'h0, crc16_poly_r};
      REG_ACK:   cfg_prdata = {27'h0, ack_thr_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // Frame store, one read port with registered data.
  logic [7:0]    store_mem [MaxLen];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  always_ff @(posedge clk) begin
    if (wr_en) store_mem[wr_addr] <= in_rx_byte;
    rd_data_r <= store_mem[rd_addr];
  end

  // Decoded beacon bytes and tie list are small register files.
  logic [7:0]    maj_r  [BEACON_OUT_BYTES];
  logic [7:0]    cand_r [BEACON_OUT_BYTES];
  logic [7:0]    cand_build [BEACON_OUT_BYTES];
  logic [PW-1:0] tie_pos_r [MAX_TIES];

  state_t          state_r, state_nxt;
  ftype_t          type_r;
  logic [AW-1:0]   cnt_r;       // bytes received
  logic [BCW-1:0]  bit_r;       // bit counter within a pass
  logic [1:0]      vote_k_r;    // copy whose bit is counted during vote
  logic [3:0]      votes_r;     // per-bit votes collected as a bit mask
  logic [TCW-1:0]  ties_r;
  logic [CW-1:0]   m_r;
  logic            fail_r;
  logic [BCW-1:0]  ones_r;
  logic [AW-1:0]   emit_r;
  logic [AW-1:0]   frame_len;
  logic [AW-1:0]   out_len;

  crc_ctl_t    crc_ctl;
  logic [15:0] crc_val;

  crad_crc_unit u_crc (
    .clk    (clk),
    .ctl    (crc_ctl),
    .poly8  (crc8_poly_r),
    .poly16 (crc16_poly_r),
    .crc    (crc_val)
  );

  ftype_t cur_type;
  assign cur_type = (cnt_r == '0) ? ftype_t'(in_frame_type) : type_r;

  always_comb begin
    unique case (cur_type)
      FT_BEACON: frame_len = AW'(BEACON_RX_BYTES);
      FT_DATA:   frame_len = AW'(DATA_BYTES);
      default:   frame_len = AW'(ACK_BYTES);
    endcase
    unique case (type_r)
      FT_BEACON: out_len = AW'(BEACON_OUT_BYTES);
      FT_DATA:   out_len = AW'(DATA_BYTES);
      default:   out_len = AW'(1);
    endcase
  end

  assign in_ready = (state_r == ST_RECV);
  logic in_fire;
  assign in_fire = in_valid && in_ready;
  assign wr_en   = in_fire && !(cnt_r == '0 && in_frame_type == FT_NONE);
  assign wr_addr = cnt_r;

  // Vote bookkeeping: bit_r walks output bits, vote_k_r walks the four copies.
  logic [BW-1:0] vbyte;
  logic [2:0]    vbit;
  assign vbyte = BW'(bit_r[BCW-1:3]);
  assign vbit  = bit_r[2:0];

  // The read for a copy is issued in the cycle before its bit is counted, so once
  // the first read is out the address runs one copy ahead of vote_k_r.
  logic [1:0] vote_rd_k;
  assign vote_rd_k = vote_k_r + {1'b0, votes_r[3]};

  // Candidate / CRC bit indexes.
  logic [BW-1:0] cbyte;
  logic [2:0]    cbit;
  assign cbyte = BW'(bit_r[BCW-1:3]);
  assign cbit  = 3'd7 - bit_r[2:0];

  logic [3:0] votes_all;
  logic [2:0] vsum;
  assign votes_all = {rd_data_r[vbit], votes_r[2:0]};
  assign vsum = 3'(votes_all[0]) + 3'(votes_all[1]) + 3'(votes_all[2]) + 3'(votes_all[3]);

  logic [BCW-1:0] pass_bits;
  assign pass_bits = (type_r == FT_DATA) ? BCW'(8 * DATA_BYTES) : BCW'(8 * ACK_BYTES);

  logic [CW-1:0] m_last;
  assign m_last = CW'((1 << ties_r) - 1);

  // Candidate for search index m_r: the majority bytes with the selected ties set.
  always_comb begin
    for (int i = 0; i < BEACON_OUT_BYTES; i++) begin
      cand_build[i] = maj_r[i];
      for (int t = 0; t < MAX_TIES; t++) begin
        if (TCW'(t) < ties_r && m_r[t] &&
            tie_pos_r[t][PW-1:3] == (PW-3)'(i)) begin
          cand_build[i][tie_pos_r[t][2:0]] = 1'b1;
        end
      end
    end
  end

  // Store read address.
  always_comb begin
    rd_addr = '0;
    unique case (state_r)
      ST_VOTE: rd_addr = AW'(32'(vote_rd_k) * BEACON_OUT_BYTES + 32'(vbyte));
      ST_CRC, ST_ACK: rd_addr = AW'(bit_r[BCW-1:3]);
      ST_CHECK, ST_EMIT: rd_addr = (state_nxt == ST_EMIT && state_r != ST_EMIT) ? '0 :
                                   emit_r + AW'(out_ready);
      default: rd_addr = '0;
    endcase
  end

  // CRC unit control.
  always_comb begin
    crc_ctl = '0;
    crc_ctl.wide = (type_r == FT_DATA);
    if (state_r == ST_CAND) crc_ctl.clear = 1'b1;
    if (state_r == ST_RECV) crc_ctl.clear = 1'b1;
    if (state_r == ST_CRC && bit_r != '0 ) begin
      crc_ctl.step = 1'b1;
    end
    // Data bits come from the registered store read; beacon bits from cand_r.
    if (type_r == FT_DATA) begin
      crc_ctl.in_bit = rd_data_r[3'd7 - (bit_r[2:0] - 3'd1)];
    end else begin
      crc_ctl.in_bit = cand_r[BW'((bit_r - 1'b1) >> 3)][3'd7 - 3'((bit_r - 1'b1))];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RECV:
        if (wr_en && cnt_r + 1'b1 == frame_len) begin
          unique case (cur_type)
            FT_BEACON: state_nxt = ST_VOTE;
            FT_DATA:   state_nxt = ST_CRC;
            default:   state_nxt = ST_ACK;
          endcase
        end
      ST_VOTE:
        if (vote_k_r == 2'd3 && bit_r == BCW'(OutBits - 1)) begin
          state_nxt = ST_CAND;
        end
      ST_CAND:
        state_nxt = ST_CRC;
      ST_CRC:
        if (type_r == FT_DATA) begin
          if (bit_r == pass_bits) state_nxt = ST_CHECK;
        end else if (ties_r > TCW'(MAX_TIES)) begin
          state_nxt = ST_CHECK;
        end else if (bit_r == BCW'(OutBits)) begin
          state_nxt = ST_CHECK;
        end
      ST_CHECK:
        if (type_r == FT_BEACON && ties_r <= TCW'(MAX_TIES) && crc_val[7:0] != 8'h0 &&
            m_r != m_last) begin
          state_nxt = ST_CAND;
        end else begin
          state_nxt = ST_EMIT;
        end
      ST_ACK:
        if (bit_r == pass_bits) state_nxt = ST_EMIT;
      ST_EMIT:
        if (out_ready && emit_r + 1'b1 == out_len) state_nxt = ST_RECV;
      default: state_nxt = ST_RECV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_RECV;
    else        state_r <= state_nxt;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      type_r   <= FT_BEACON;
      bit_r    <= '0;
      vote_k_r <= '0;
      ties_r   <= '0;
      m_r      <= '0;
      fail_r   <= 1'b0;
      ones_r   <= '0;
      emit_r   <= '0;
      votes_r  <= '0;
    end else begin
      unique case (state_r)
        ST_RECV: begin
          if (wr_en) begin
            if (cnt_r == '0) type_r <= ftype_t'(in_frame_type);
            cnt_r <= (cnt_r + 1'b1 == frame_len) ? '0 : cnt_r + 1'b1;
          end
          bit_r    <= '0;
          vote_k_r <= '0;
          ties_r   <= '0;
          m_r      <= '0;
          ones_r   <= '0;
          emit_r   <= '0;
          votes_r  <= '0;
        end
        ST_VOTE: begin
          // First cycle of a bit issues the read; results arrive in the next cycle.
          if (!votes_r[3]) begin
            votes_r <= 4'b1000;
          end else if (vote_k_r == 2'd3) begin
            if (vsum >= 3'd3) maj_r[vbyte][vbit] <= 1'b1;
            else              maj_r[vbyte][vbit] <= 1'b0;
            if (vsum == 3'd2) begin
              for (int t = 0; t < MAX_TIES; t++) begin
                if (ties_r == TCW'(t)) tie_pos_r[t] <= PW'(bit_r);
              end
              if (ties_r != TCW'(OutBits)) ties_r <= ties_r + 1'b1;
            end
            bit_r   <= (bit_r == BCW'(OutBits - 1)) ? '0 : bit_r + 1'b1;
            votes_r <= 4'b0000;
          end else begin
            votes_r <= {1'b1, votes_all[3:1]};
          end
          vote_k_r <= votes_r[3] ? vote_k_r + 2'd1 : vote_k_r;
        end
        ST_CAND: begin
          for (int i = 0; i < BEACON_OUT_BYTES; i++) begin
            cand_r[i] <= cand_build[i];
          end
          bit_r <= '0;
        end
        ST_CRC: begin
          bit_r <= bit_r + 1'b1;
        end
        ST_CHECK: begin
          bit_r <= '0;
          if (type_r == FT_DATA) begin
            fail_r <= (crc_val != 16'h0);
          end else begin
            fail_r <= (ties_r > TCW'(MAX_TIES)) || (crc_val[7:0] != 8'h0);
            if (ties_r > TCW'(MAX_TIES)) begin
              for (int i = 0; i < BEACON_OUT_BYTES; i++) cand_r[i] <= maj_r[i];
            end
            m_r <= m_r + 1'b1;
          end
        end
        ST_ACK: begin
          bit_r <= bit_r + 1'b1;
          if (bit_r != '0) begin
            ones_r <= ones_r + BCW'(rd_data_r[3'(bit_r - 1'b1)]);
          end
          fail_r <= 1'b0;
        end
        ST_EMIT: begin
          if (out_ready) emit_r <= emit_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Output selection. The data store read is registered, so emission of data
  // bytes uses rd_data_r, whose address is issued in the cycle before.
  logic ack_set;
  assign ack_set = (ones_r >= BCW'(ack_thr_r));

  always_comb begin
    out_valid        = (state_r == ST_EMIT);
    out_last_of_run  = (emit_r + 1'b1 == out_len);
    out_check_failed = fail_r;
    unique case (type_r)
      FT_BEACON: out_out_byte = cand_r[BW'(emit_r)];
      FT_DATA:   out_out_byte = rd_data_r;
      default:   out_out_byte = ack_set ? AckSetByte : 8'h00;
    endcase
  end

`ifndef SYNTH
  // No input is taken while a decoded frame is being delivered.
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted during output");

  // A stalled result holds its byte.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_out_byte))
    else $error("output changed while stalled");

  // Acknowledge results never flag a failure and are always the last of their run.
  a_ack_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && type_r == FT_ACK |-> !out_check_failed && out_last_of_run)
    else $error("bad acknowledge result");
`endif

endmodule

// ===== dv/crad_frame_checker.sv =====
// Checker that predicts the decoded bytes of each frame and compares them with the output.
module crad_frame_checker
  import crad_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_frame_type,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_out_byte,
  input  logic        out_check_failed,
  input  logic        out_last_of_run,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [7:0] data;
    logic       failed;
    logic       last;
  } decoded_t;

  decoded_t   decoded_q[$];
  logic [8:0]  crc8_poly;
  logic [16:0] crc16_poly;
  logic [4:0]  ack_thresh;
  logic [7:0]  frame_bytes[DataBytes + BeaconRxBytes];
  int          rx_count;
  ftype_t      frame_kind;

  assign pending_count = decoded_q.size();

  function automatic logic [15:0] crc_of(input logic [7:0] buf_b[], input int n,
                                         input bit wide, input logic [16:0] poly);
    logic [15:0] reg_v;
    logic [15:0] mask;
    logic        fb;
    reg_v = '0;
    mask = wide ? 16'hFFFF : 16'h00FF;
    for (int i = 0; i < n; i++) begin
      for (int b = 7; b >= 0; b--) begin
        fb = (wide ? reg_v[15] : reg_v[7]) ^ buf_b[i][b];
        reg_v = (reg_v << 1) & mask;
        if (fb) reg_v ^= poly[15:0] & mask;
      end
    end
    return reg_v;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    fail_count++;
  endtask

  task automatic predict_beacon();
    logic [7:0] maj[] = new[BeaconOutBytes];
    logic [7:0] cand[] = new[BeaconOutBytes];
    int         tie_pos[MaxTies];
    int         ties;
    int         votes;
    bit         failed;
    ties = 0;
    failed = 1;
    for (int i = 0; i < BeaconOutBytes; i++) begin
      maj[i] = '0;
      for (int b = 0; b < 8; b++) begin
        votes = 0;
        for (int k = 0; k < 4; k++) votes += frame_bytes[k * BeaconOutBytes + i][b];
        if (votes >= 3) maj[i][b] = 1'b1;
        else if (votes == 2) begin
          if (ties < MaxTies) tie_pos[ties] = i * 8 + b;
          ties++;
        end
      end
    end
    cand = maj;
    if (ties <= MaxTies) begin
      for (int m = 0; m < (1 << ties); m++) begin
        cand = maj;
        for (int t = 0; t < ties; t++)
          if (m[t]) cand[tie_pos[t] / 8][tie_pos[t] % 8] = 1'b1;
        if (crc_of(cand, BeaconOutBytes, 1'b0, {8'd0, crc8_poly}) == 0) begin
          failed = 0;
          break;
        end
      end
    end
    for (int i = 0; i < BeaconOutBytes; i++)
      decoded_q.push_back('{cand[i], failed, i == BeaconOutBytes - 1});
  endtask

  task automatic predict_data();
    logic [7:0] d[] = new[DataBytes];
    bit         failed;
    for (int i = 0; i < DataBytes; i++) d[i] = frame_bytes[i];
    failed = crc_of(d, DataBytes, 1'b1, crc16_poly) != 0;
    for (int i = 0; i < DataBytes; i++)
      decoded_q.push_back('{d[i], failed, i == DataBytes - 1});
  endtask

  task automatic predict_ack();
    int ones;
    ones = 0;
    for (int i = 0; i < AckBytes; i++) ones += $countones(frame_bytes[i]);
    decoded_q.push_back('{(ones >= ack_thresh) ? AckSetByte : 8'h00, 1'b0, 1'b1});
  endtask

  always @(posedge clk) begin
    decoded_t want;
    int       len;
    if (!rst_n) begin
      crc8_poly  <= Crc8PolyReset;
      crc16_poly <= Crc16PolyReset;
      ack_thresh <= AckThreshReset;
      rx_count   = 0;
      frame_kind = FT_BEACON;
      fail_count = 0;
      decoded_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_CRC8:  crc8_poly  <= cfg_pwdata[8:0];
          REG_CRC16: crc16_poly <= cfg_pwdata[16:0];
          REG_ACK:   ack_thresh <= cfg_pwdata[4:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready && !(rx_count == 0 && in_frame_type == FT_NONE)) begin
        if (rx_count == 0) frame_kind = ftype_t'(in_frame_type);
        len = (frame_kind == FT_BEACON) ? BeaconRxBytes :
              (frame_kind == FT_DATA) ? DataBytes : AckBytes;
        frame_bytes[rx_count] = in_rx_byte;
        rx_count++;
        if (rx_count == len) begin
          rx_count = 0;
          case (frame_kind)
            FT_BEACON: predict_beacon();
            FT_DATA:   predict_data();
            default:   predict_ack();
          endcase
        end
      end
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected item", out_out_byte, 0);
        end else begin
          want = decoded_q.pop_front();
          if (out_out_byte !== want.data) report_mismatch("out_byte", out_out_byte, want.data);
          if (out_check_failed !== want.failed)
            report_mismatch("check_failed", out_check_failed, want.failed);
          if (out_last_of_run !== want.last)
            report_mismatch("last_of_run", out_last_of_run, want.last);
        end
      end
    end
  end

endmodule

// ===== dv/tb_crc_aided_repetition_decoder_top.sv =====
// Testbench top: drives frames and register writes into the decoder and gives the verdict.
module tb_crc_aided_repetition_decoder_top;
  import crad_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_frame_type = '0;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_out_byte;
  logic        out_check_failed;
  logic        out_last_of_run;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int pending_count;

  // Knobs shared by the stimulus and the receiver processes.
  bit steady_phase = 0;    // no idling on either side while set
  bit hold_receiver = 0;   // request for a long receiver hold-off
  int item_total = 0;
  int results_seen = 0;

  always #1 clk = ~clk;

  crc_aided_repetition_decoder_top uut (.*);

  crad_frame_checker checker_i (.*);

  always @(posedge clk) if (out_valid && out_ready) results_seen++;

  // Polynomial encoders used to build frames that pass their check, so that the
  // tie search and the clean data path are exercised rather than only failures.
  logic [8:0]  crc8_poly_now  = Crc8PolyReset;
  logic [16:0] crc16_poly_now = Crc16PolyReset;

  function automatic logic [15:0] run_crc(input logic [7:0] b[], input int n, input bit wide,
                                          input logic [16:0] poly);
    logic [15:0] r;
    logic [15:0] mask;
    logic        fb;
    r = '0;
    mask = wide ? 16'hFFFF : 16'h00FF;
    for (int i = 0; i < n; i++)
      for (int k = 7; k >= 0; k--) begin
        fb = (wide ? r[15] : r[7]) ^ b[i][k];
        r = (r << 1) & mask;
        if (fb) r ^= poly[15:0] & mask;
      end
    return r;
  endfunction

  // Sends one byte: valid goes up on a falling edge and stays until accepted.
  // Valid is left high afterwards; the next byte or an idle cycle replaces it.
  task automatic send_byte(input logic [1:0] kind, input logic [7:0] value);
    while (!steady_phase && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_frame_type <= kind;
    in_rx_byte <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    item_total++;
    @(negedge clk);
  endtask

  // A data frame; when clean, the last two bytes make the 16-bit syndrome zero.
  // The syndrome is linear in the tail, so the tail is solved for from one column per tail bit.
  task automatic send_data(input bit clean);
    logic [7:0] d[] = new[DataBytes];
    logic [15:0] base;
    logic [15:0] tail;
    logic [15:0] col[16];
    foreach (d[i]) d[i] = 8'($urandom_range(255));
    if (clean) begin
      d[DataBytes - 2] = 0;
      d[DataBytes - 1] = 0;
      base = run_crc(d, DataBytes, 1, crc16_poly_now);
      for (int k = 0; k < 16; k++) begin
        {d[DataBytes - 2], d[DataBytes - 1]} = 16'(1) << k;
        col[k] = run_crc(d, DataBytes, 1, crc16_poly_now) ^ base;
      end
      // Gaussian elimination over GF(2) to find the tail that cancels base.
      tail = 0;
      begin
        logic [15:0] rows[16];
        logic [15:0] combo[16];
        logic [15:0] target;
        logic [15:0] sol;
        int used;
        used = 0;
        target = base;
        sol = 0;
        for (int k = 0; k < 16; k++) begin
          rows[k] = col[k];
          combo[k] = 16'(1) << k;
        end
        for (int bitp = 15; bitp >= 0; bitp--) begin
          int piv;
          piv = -1;
          for (int k = used; k < 16; k++) if (rows[k][bitp] && piv < 0) piv = k;
          if (piv >= 0) begin
            {rows[piv], rows[used]} = {rows[used], rows[piv]};
            {combo[piv], combo[used]} = {combo[used], combo[piv]};
            for (int k = 0; k < 16; k++)
              if (k != used && rows[k][bitp]) begin
                rows[k] ^= rows[used];
                combo[k] ^= combo[used];
              end
            if (target[bitp]) begin
              target ^= rows[used];
              sol ^= combo[used];
            end
            used++;
          end
        end
        tail = sol;
      end
      {d[DataBytes - 2], d[DataBytes - 1]} = tail;
    end
    foreach (d[i]) send_byte(FT_DATA, d[i]);
  endtask

  // A beacon frame: a block ending in a CRC-8 byte is repeated four times and
  // some copies are disturbed so that chosen bits tie; noisy frames are random.
  task automatic send_beacon(input int tie_goal, input bit noisy);
    logic [7:0] blk[] = new[BeaconOutBytes];
    logic [7:0] cp[4][BeaconOutBytes];
    int pos;
    for (int i = 0; i < BeaconOutBytes; i++) blk[i] = 8'($urandom_range(255));
    blk[BeaconOutBytes - 1] = 0;
    for (int v = 0; v < 256; v++) begin
      blk[BeaconOutBytes - 1] = 8'(v);
      if (run_crc(blk, BeaconOutBytes, 0, {8'd0, crc8_poly_now}) == 0) break;
    end
    for (int k = 0; k < 4; k++)
      for (int i = 0; i < BeaconOutBytes; i++)
        cp[k][i] = noisy ? 8'($urandom_range(255)) : blk[i];
    for (int t = 0; t < tie_goal; t++) begin
      pos = $urandom_range(8 * BeaconOutBytes - 1);
      cp[0][pos / 8][pos % 8] = ~cp[0][pos / 8][pos % 8];
      cp[2][pos / 8][pos % 8] = ~cp[2][pos / 8][pos % 8];
    end
    if (!noisy && $urandom_range(3) == 0) begin
      pos = $urandom_range(8 * BeaconOutBytes - 1);
      cp[3][pos / 8][pos % 8] = ~cp[3][pos / 8][pos % 8];
    end
    for (int k = 0; k < 4; k++)
      for (int i = 0; i < BeaconOutBytes; i++) send_byte(FT_BEACON, cp[k][i]);
  endtask

  task automatic send_ack(input logic [7:0] a, input logic [7:0] b);
    send_byte(FT_ACK, a);
    send_byte(FT_ACK, b);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    // An ignored or partial frame leaves nothing pending; give the decode time.
    repeat (1000) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_CRC8:  crc8_poly_now = value[8:0];
      REG_CRC16: crc16_poly_now = value[16:0];
      default: ;
    endcase
  endtask

  // Receiver: random stalls, a steady stretch, and one long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_receiver) begin
        out_ready <= 1'b0;
        repeat (3000) @(negedge clk);
        hold_receiver = 0;
      end
      out_ready <= steady_phase || ($urandom_range(99) >= 14);
    end
  end

  initial begin
    int kind;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes of the acknowledge count against default threshold.
    send_ack(8'h00, 8'h00);
    send_ack(8'hFF, 8'hFF);
    send_ack(8'hF0, 8'h3F);   // exactly ten ones
    send_ack(8'hF0, 8'h1F);   // nine ones
    // A first byte of the unknown type is dropped.
    send_byte(FT_NONE, 8'hA5);
    send_byte(FT_NONE, 8'h5A);
    send_data(1);
    send_beacon(2, 0);
    send_beacon(7, 0);        // too many ties, no search
    wait_drained();

    // Extremes of every register.
    write_reg(REG_ACK, 32'd0);
    write_reg(REG_CRC8, 32'h100);
    write_reg(REG_CRC16, 32'h1_0000);
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    send_ack(8'h00, 8'h00);
    send_beacon(3, 0);
    send_data(0);
    wait_drained();
    write_reg(REG_ACK, 32'd16);
    write_reg(REG_CRC8, 32'h1FF);
    write_reg(REG_CRC16, 32'h1_FFFF);
    // A stretch with no idling on either side.
    steady_phase = 1;
    send_ack(8'hFF, 8'hFF);
    send_ack(8'hFF, 8'hFE);
    send_beacon(1, 0);
    wait_drained();
    steady_phase = 0;
    write_reg(REG_ACK, 32'd31);
    send_ack(8'hFF, 8'hFF);
    wait_drained();

    // Pressure: hold the receiver off while frames keep coming.
    write_reg(REG_ACK, 32'(AckThreshReset));
    write_reg(REG_CRC8, 32'(Crc8PolyReset));
    write_reg(REG_CRC16, 32'(Crc16PolyReset));
    hold_receiver = 1;
    send_data(1);
    send_beacon(4, 0);
    wait_drained();

    // Random part in phases, each with fresh register settings.
    for (int phase = 0; phase < 2; phase++) begin
      write_reg(REG_CRC8, 32'($urandom_range(511, 256)));
      write_reg(REG_CRC16, 32'($urandom_range(131071, 65536)));
      write_reg(REG_ACK, 32'($urandom_range(16)));
      for (int n = 0; n < 2; n++) begin
        kind = $urandom_range(99);
        if (kind < 35) send_beacon($urandom_range(6), $urandom_range(9) == 0);
        else if (kind < 55) send_data($urandom_range(3) != 0);
        else if (kind < 90) send_ack(8'($urandom), 8'($urandom));
        else send_byte(FT_NONE, 8'($urandom));
      end
      wait_drained();
    end

    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("crc_aided_repetition_decoder_top test passed");
    end else begin
      $display("crc_aided_repetition_decoder_top test failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("crc_aided_repetition_decoder_top test failed");
    $finish;
  end

endmodule
